[design/ucep_pkg.sv]
// ucep_pkg: shared types and codes of the control endpoint sequencer
// no dependencies; imported by ucep_front, ucep_back and the top level
package ucep_pkg;

  localparam int unsigned SetupPacketBytes = 8;
  localparam int unsigned LenStateMax      = 2047;

  typedef enum logic [2:0] {
    EV_ATTACH  = 3'd0,
    EV_DETACH  = 3'd1,
    EV_RESET   = 3'd2,
    EV_SETUP   = 3'd3,
    EV_IN      = 3'd4,
    EV_OUT     = 3'd5,
    EV_SETADDR = 3'd6,
    EV_UNKNOWN = 3'd7
  } ev_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_NODEV = 3'd1,
    ST_STALL = 3'd2,
    ST_HERR  = 3'd3,
    ST_FWD   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DATA = 2'd1,
    PH_ACK  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    AT_NONE     = 2'd0,
    AT_ATTACHED = 2'd1,
    AT_DEFAULT  = 2'd2
  } attach_e;

  typedef enum logic [1:0] {
    CD_NONE        = 2'd0,
    CD_BUF_TO_HOST = 2'd1,
    CD_HOST_TO_BUF = 2'd2
  } copy_dir_e;

  // classified token as it leaves the front end
  typedef struct packed {
    ev_e         ev;
    logic [6:0]  addr;
    logic        ep_zero;
    logic [9:0]  plen;
    logic        setup_ok;
    logic        dir_in;
    logic [10:0] req_len;
    logic        hfail;
    logic [10:0] hlen;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [9:0]  byte_count;
    logic [10:0] buffer_offset;
    copy_dir_e   copy_dir;
    logic        run_reset;
    logic        handler_invoked;
  } res_t;

endpackage

[design/ucep_fifo.sv]
// ucep_fifo: small flip-flop queue with push/full and pop/empty sides
// no package dependencies; used for the command and result queues
module ucep_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[design/ucep_front.sv]
// ucep_front: decodes a bus event or token into a classified command
// depends on ucep_pkg; feeds the command queue
module ucep_front
  import ucep_pkg::*;
#(
  parameter int unsigned CONTROL_BUFFER_BYTES = 1024
) (
  input  logic [2:0]  req_type_i,
  input  logic [6:0]  dev_addr_i,
  input  logic [3:0]  endpoint_i,
  input  logic [9:0]  packet_length_i,
  input  logic [7:0]  request_type_byte_i,
  input  logic [15:0] request_length_i,
  input  logic        handler_failed_i,
  input  logic [10:0] handler_length_i,
  output cmd_t        cmd_o
);

  // buffer size capped to what the length state can hold
  localparam int unsigned LenCap =
    (CONTROL_BUFFER_BYTES > LenStateMax) ? LenStateMax : CONTROL_BUFFER_BYTES;

  always_comb begin
    cmd_o.ev       = ev_e'(req_type_i);
    cmd_o.addr     = dev_addr_i;
    cmd_o.ep_zero  = (endpoint_i == 4'd0);
    cmd_o.plen     = packet_length_i;
    cmd_o.setup_ok = (packet_length_i == 10'(SetupPacketBytes));
    cmd_o.dir_in   = request_type_byte_i[7];
    cmd_o.req_len  = (request_length_i > 16'(LenCap)) ? 11'(LenCap)
                                                      : request_length_i[10:0];
    cmd_o.hfail    = handler_failed_i;
    cmd_o.hlen     = handler_length_i;
  end

endmodule

[design/ucep_back.sv]
// ucep_back: holds the endpoint state and carries out one command a cycle while the result queue has room
// depends on ucep_pkg; reads the command queue, writes the result queue
module ucep_back
  import ucep_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic res_full_i,
  output logic res_push_o,
  output res_t res_o
);

  attach_e     attach_q, attach_d;
  logic [6:0]  addr_q, addr_d;
  logic        stalled_q, stalled_d;
  phase_e      phase_q, phase_d;
  logic        dir_in_q, dir_in_d;
  logic [10:0] len_q, len_d;
  logic [10:0] off_q, off_d;

  logic        fire;
  logic        stall_now;
  logic [10:0] left;
  logic [9:0]  chunk;
  logic [10:0] next_off;

  assign fire       = cmd_valid_i && !res_full_i;
  assign cmd_pop_o  = fire;
  assign res_push_o = fire;

  // bytes left in the transfer, limited to the token payload
  assign left     = (off_q > len_q) ? 11'd0 : len_q - off_q;
  assign chunk    = (left < {1'b0, cmd_i.plen}) ? left[9:0] : cmd_i.plen;
  assign next_off = off_q + {1'b0, chunk};

  always_comb begin
    attach_d  = attach_q;
    addr_d    = addr_q;
    stalled_d = stalled_q;
    phase_d   = phase_q;
    dir_in_d  = dir_in_q;
    len_d     = len_q;
    off_d     = off_q;
    stall_now = 1'b0;
    res_o     = '{status: ST_OK, byte_count: '0, buffer_offset: '0,
                  copy_dir: CD_NONE, run_reset: 1'b0, handler_invoked: 1'b0};

    case (cmd_i.ev)
      EV_ATTACH: attach_d = AT_ATTACHED;
      EV_DETACH: attach_d = AT_NONE;
      EV_RESET: begin
        addr_d          = '0;
        attach_d        = AT_DEFAULT;
        res_o.run_reset = 1'b1;
      end
      EV_SETADDR: addr_d = cmd_i.addr;
      EV_SETUP, EV_IN, EV_OUT: begin
        if (attach_q != AT_DEFAULT || cmd_i.addr != addr_q) begin
          res_o.status = ST_NODEV;
        end else if (cmd_i.ev == EV_SETUP) begin
          if (!cmd_i.setup_ok) begin
            stall_now = 1'b1;
          end else begin
            stalled_d = 1'b0;
            dir_in_d  = cmd_i.dir_in;
            len_d     = cmd_i.req_len;
            off_d     = '0;
            if (cmd_i.dir_in) begin
              res_o.handler_invoked = 1'b1;
              if (cmd_i.hfail) begin
                res_o.status = ST_HERR;
              end else begin
                if (cmd_i.hlen < cmd_i.req_len) begin
                  len_d = cmd_i.hlen;
                end
                phase_d = PH_DATA;
              end
            end else begin
              phase_d = (cmd_i.req_len == '0) ? PH_ACK : PH_DATA;
            end
          end
        end else if (stalled_q) begin
          res_o.status = ST_STALL;
        end else if (!cmd_i.ep_zero) begin
          res_o.status = ST_FWD;
        end else if (cmd_i.ev == EV_IN) begin
          case (phase_q)
            PH_ACK: begin
              if (!dir_in_q) begin
                phase_d               = PH_IDLE;
                res_o.handler_invoked = 1'b1;
                if (cmd_i.hfail) begin
                  res_o.status = ST_HERR;
                end
              end
            end
            PH_DATA: begin
              if (dir_in_q) begin
                res_o.byte_count    = chunk;
                res_o.buffer_offset = off_q;
                res_o.copy_dir      = CD_BUF_TO_HOST;
                off_d               = next_off;
                if (next_off >= len_q) begin
                  phase_d = PH_ACK;
                end
              end else begin
                phase_d   = PH_IDLE;
                stall_now = 1'b1;
              end
            end
            default: stall_now = 1'b1;
          endcase
        end else begin
          case (phase_q)
            PH_ACK: begin
              if (dir_in_q) begin
                phase_d = PH_IDLE;
              end
            end
            PH_DATA: begin
              if (!dir_in_q) begin
                res_o.byte_count    = chunk;
                res_o.buffer_offset = off_q;
                res_o.copy_dir      = CD_HOST_TO_BUF;
                off_d               = next_off;
                if (next_off >= len_q) begin
                  phase_d = PH_ACK;
                end
              end else begin
                // early out ends a device-to-host transfer
                phase_d = PH_IDLE;
              end
            end
            default: stall_now = 1'b1;
          endcase
        end
      end
      default: stall_now = 1'b1;
    endcase

    if (stall_now) begin
      stalled_d    = 1'b1;
      res_o.status = ST_STALL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attach_q  <= AT_NONE;
      addr_q    <= '0;
      stalled_q <= 1'b0;
      phase_q   <= PH_IDLE;
      dir_in_q  <= 1'b0;
      len_q     <= '0;
      off_q     <= '0;
    end else if (fire) begin
      attach_q  <= attach_d;
      addr_q    <= addr_d;
      stalled_q <= stalled_d;
      phase_q   <= phase_d;
      dir_in_q  <= dir_in_d;
      len_q     <= len_d;
      off_q     <= off_d;
    end
  end

endmodule

[design/usb_control_endpoint_sequencer_top.sv]
// a token waits in the command queue and its result is registered in the result queue
// throughput: one token per cycle while the result queue has room, set by the back end
// two-entry command and result queues let either side stall; a full one takes no push
// reset: asynchronous, active low; empties both queues, device detached, address 0, idle
// depends on ucep_pkg, ucep_fifo, ucep_front and ucep_back
module usb_control_endpoint_sequencer_top
  import ucep_pkg::*;
#(
  parameter int unsigned CONTROL_BUFFER_BYTES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  req_type_i,
  input  logic [6:0]  dev_addr_i,
  input  logic [3:0]  endpoint_i,
  input  logic [9:0]  packet_length_i,
  input  logic [7:0]  request_type_byte_i,
  input  logic [15:0] request_length_i,
  input  logic        handler_failed_i,
  input  logic [10:0] handler_length_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic [9:0]  byte_count_o,
  output logic [10:0] buffer_offset_o,
  output logic [1:0]  copy_direction_o,
  output logic        run_reset_o,
  output logic        handler_invoked_o
);

  cmd_t cmd_in, cmd_out;
  res_t res_in, res_out;
  logic cmd_empty, cmd_pop;
  logic res_full, res_push;

  ucep_front #(
    .CONTROL_BUFFER_BYTES(CONTROL_BUFFER_BYTES)
  ) u_front (
    .req_type_i         (req_type_i),
    .dev_addr_i         (dev_addr_i),
    .endpoint_i         (endpoint_i),
    .packet_length_i    (packet_length_i),
    .request_type_byte_i(request_type_byte_i),
    .request_length_i   (request_length_i),
    .handler_failed_i   (handler_failed_i),
    .handler_length_i   (handler_length_i),
    .cmd_o              (cmd_in)
  );

  ucep_fifo #(
    .Width($bits(cmd_t)),
    .Depth(2)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(cmd_in),
    .full_o (full),
    .pop_i  (cmd_pop),
    .rdata_o(cmd_out),
    .empty_o(cmd_empty)
  );

  ucep_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(!cmd_empty),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  ucep_fifo #(
    .Width($bits(res_t)),
    .Depth(2)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_out),
    .empty_o(empty)
  );

  assign status_o          = res_out.status;
  assign byte_count_o      = res_out.byte_count;
  assign buffer_offset_o   = res_out.buffer_offset;
  assign copy_direction_o  = res_out.copy_dir;
  assign run_reset_o       = res_out.run_reset;
  assign handler_invoked_o = res_out.handler_invoked;

`ifndef SYNTH
  // back end only writes a result when the result queue has room
  a_res_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full && !cmd_empty)
    else $error("result written into a full queue");

  // a token that copies nothing reports no bytes
  a_no_copy_no_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && copy_direction_o == CD_NONE) |-> byte_count_o == 10'd0)
    else $error("byte count without a copy");

  // bus reset never reports a failure
  a_reset_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && run_reset_o) |-> (status_o == ST_OK && !handler_invoked_o))
    else $error("run_reset with bad status");

  // handler runs only on steps that end ok or with a handler error
  a_handler_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && handler_invoked_o) |-> (status_o == ST_OK || status_o == ST_HERR))
    else $error("handler invoked with unexpected status");
`endif

endmodule

[bench/ucep_tb_pkg.sv]
// ucep_tb_pkg: token type and control-transfer scoreboard for the sequencer bench
// depends on ucep_pkg for the event, status, phase and copy-direction codes
package ucep_tb_pkg;
  import ucep_pkg::*;

  localparam int unsigned BufferBytes = 1024;
  localparam logic [10:0] LenCap = 11'((BufferBytes > LenStateMax) ? LenStateMax : BufferBytes);

  typedef struct packed {
    ev_e         ev;
    logic [6:0]  addr;
    logic [3:0]  ep;
    logic [9:0]  plen;
    logic [7:0]  rtb;
    logic [15:0] rlen;
    logic        hfail;
    logic [10:0] hlen;
  } token_t;

  class control_xfer_scoreboard;
    attach_e     attach;
    logic [6:0]  address;
    logic        stalled;
    phase_e      phase;
    logic        dir_in;
    logic [10:0] xfer_len;
    logic [10:0] xfer_off;
    res_t        pending_results[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      attach     = AT_NONE;
      address    = '0;
      stalled    = 1'b0;
      phase      = PH_IDLE;
      dir_in     = 1'b0;
      xfer_len   = '0;
      xfer_off   = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    // bytes left in the transfer, limited by the token's packet size
    function logic [10:0] chunk_len(logic [9:0] pkt);
      logic [10:0] left;
      left = (xfer_off > xfer_len) ? 11'd0 : xfer_len - xfer_off;
      return (left > {1'b0, pkt}) ? {1'b0, pkt} : left;
    endfunction

    function void note_token(token_t t);
      res_t        r;
      logic        stall_now;
      logic [10:0] n;
      r         = '0;
      stall_now = 1'b0;
      case (t.ev)
        EV_ATTACH: attach = AT_ATTACHED;
        EV_DETACH: attach = AT_NONE;
        EV_RESET: begin
          address     = '0;
          attach      = AT_DEFAULT;
          r.run_reset = 1'b1;
        end
        EV_SETADDR: address = t.addr;
        EV_SETUP, EV_IN, EV_OUT: begin
          if (attach != AT_DEFAULT || t.addr != address) begin
            r.status = ST_NODEV;
          end else if (t.ev == EV_SETUP) begin
            if (t.plen != 10'(SetupPacketBytes)) begin
              stall_now = 1'b1;
            end else begin
              stalled  = 1'b0;
              dir_in   = t.rtb[7];
              xfer_len = (t.rlen > 16'(LenCap)) ? LenCap : t.rlen[10:0];
              xfer_off = '0;
              if (dir_in) begin
                r.handler_invoked = 1'b1;
                // a failed handler leaves the phase where it was
                if (t.hfail) begin
                  r.status = ST_HERR;
                end else begin
                  if (t.hlen < xfer_len) xfer_len = t.hlen;
                  phase = PH_DATA;
                end
              end else begin
                phase = (xfer_len == 0) ? PH_ACK : PH_DATA;
              end
            end
          end else if (stalled) begin
            r.status = ST_STALL;
          end else if (t.ep != 4'd0) begin
            r.status = ST_FWD;
          end else if (t.ev == EV_IN) begin
            case (phase)
              PH_ACK: begin
                if (!dir_in) begin
                  phase             = PH_IDLE;
                  r.handler_invoked = 1'b1;
                  if (t.hfail) r.status = ST_HERR;
                end
              end
              PH_DATA: begin
                if (dir_in) begin
                  n               = chunk_len(t.plen);
                  r.byte_count    = n[9:0];
                  r.buffer_offset = xfer_off;
                  r.copy_dir      = CD_BUF_TO_HOST;
                  xfer_off        = xfer_off + n;
                  if (xfer_off >= xfer_len) phase = PH_ACK;
                end else begin
                  phase     = PH_IDLE;
                  stall_now = 1'b1;
                end
              end
              default: stall_now = 1'b1;
            endcase
          end else begin
            case (phase)
              // extra out in the status stage of a host-to-device transfer is ignored
              PH_ACK: begin
                if (dir_in) phase = PH_IDLE;
              end
              PH_DATA: begin
                if (!dir_in) begin
                  n               = chunk_len(t.plen);
                  r.byte_count    = n[9:0];
                  r.buffer_offset = xfer_off;
                  r.copy_dir      = CD_HOST_TO_BUF;
                  xfer_off        = xfer_off + n;
                  if (xfer_off >= xfer_len) phase = PH_ACK;
                end else begin
                  // host cut the in transfer short
                  phase = PH_IDLE;
                end
              end
              default: stall_now = 1'b1;
            endcase
          end
        end
        default: stall_now = 1'b1;
      endcase
      if (stall_now) begin
        stalled  = 1'b1;
        r.status = ST_STALL;
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t want;
      checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result #%0d with no transaction waiting: status %0d count %0d",
                   checked, got.status, got.byte_count);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.byte_count !== want.byte_count ||
          got.buffer_offset !== want.buffer_offset || got.copy_dir !== want.copy_dir ||
          got.run_reset !== want.run_reset ||
          got.handler_invoked !== want.handler_invoked) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result #%0d mismatch, expected st %0d cnt %0d off %0d dir %0d rr %0d hi %0d",
                   checked, want.status, want.byte_count, want.buffer_offset,
                   want.copy_dir, want.run_reset, want.handler_invoked);
          $display("  actual st %0d cnt %0d off %0d dir %0d rr %0d hi %0d",
                   got.status, got.byte_count, got.buffer_offset,
                   got.copy_dir, got.run_reset, got.handler_invoked);
        end
      end
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void close_out();
      if (pending_results.size() != 0) begin
        $display("%0d expected results never arrived", pending_results.size());
        mismatches += pending_results.size();
      end
    endfunction
  endclass

endpackage

[bench/tb_top.sv]
// tb_top: drives bus events and tokens into the control endpoint sequencer and
// checks every result against the scoreboard; depends on ucep_pkg and ucep_tb_pkg
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ucep_pkg::*;
  import ucep_tb_pkg::*;

  localparam int unsigned NumItems     = 1750;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned HoldAtResult = 500;
  localparam int unsigned DrainAtItem  = 1000;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push;
  logic        full;
  logic [2:0]  req_type_i;
  logic [6:0]  dev_addr_i;
  logic [3:0]  endpoint_i;
  logic [9:0]  packet_length_i;
  logic [7:0]  request_type_byte_i;
  logic [15:0] request_length_i;
  logic        handler_failed_i;
  logic [10:0] handler_length_i;
  logic        empty;
  logic        pop;
  logic [2:0]  status_o;
  logic [9:0]  byte_count_o;
  logic [10:0] buffer_offset_o;
  logic [1:0]  copy_direction_o;
  logic        run_reset_o;
  logic        handler_invoked_o;

  logic        full_s  = 1'b1;
  logic        empty_s = 1'b1;
  res_t        res_s;
  bit          no_idle = 1'b0;
  int unsigned sent    = 0;
  int unsigned cycle_count = 0;

  control_xfer_scoreboard sb;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  usb_control_endpoint_sequencer_top dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .push                (push),
    .full                (full),
    .req_type_i          (req_type_i),
    .dev_addr_i          (dev_addr_i),
    .endpoint_i          (endpoint_i),
    .packet_length_i     (packet_length_i),
    .request_type_byte_i (request_type_byte_i),
    .request_length_i    (request_length_i),
    .handler_failed_i    (handler_failed_i),
    .handler_length_i    (handler_length_i),
    .empty               (empty),
    .pop                 (pop),
    .status_o            (status_o),
    .byte_count_o        (byte_count_o),
    .buffer_offset_o     (buffer_offset_o),
    .copy_direction_o    (copy_direction_o),
    .run_reset_o         (run_reset_o),
    .handler_invoked_o   (handler_invoked_o)
  );

  // outputs settle between edges; sample them mid-cycle
  always @(negedge clk_i) begin
    full_s                 <= full;
    empty_s                <= empty;
    res_s.status           <= status_e'(status_o);
    res_s.byte_count       <= byte_count_o;
    res_s.buffer_offset    <= buffer_offset_o;
    res_s.copy_dir         <= copy_dir_e'(copy_direction_o);
    res_s.run_reset        <= run_reset_o;
    res_s.handler_invoked  <= handler_invoked_o;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random pops, plus one long hold-off to back the block up
  initial begin
    bit          held;
    int unsigned hold_left;
    held      = 1'b0;
    hold_left = 0;
    pop <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty_s) sb.check_result(res_s);
      if (!held && sb.checked >= HoldAtResult) begin
        held      = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) hold_left--;
      pop <= (hold_left == 0) && (no_idle || $urandom_range(0, 99) >= 32);
    end
  end

  function automatic token_t make_token(ev_e ev, logic [6:0] addr, logic [3:0] ep,
                                        logic [9:0] plen, logic [7:0] rtb,
                                        logic [15:0] rlen, logic hfail, logic [10:0] hlen);
    token_t t;
    t.ev    = ev;
    t.addr  = addr;
    t.ep    = ep;
    t.plen  = plen;
    t.rtb   = rtb;
    t.rlen  = rlen;
    t.hfail = hfail;
    t.hlen  = hlen;
    return t;
  endfunction

  function automatic token_t random_token();
    token_t t;
    t.ev    = ev_e'($urandom_range(0, 7));
    t.addr  = $urandom_range(0, 1) ? sb.address : 7'($urandom);
    t.ep    = 4'($urandom);
    t.plen  = 10'($urandom);
    t.rtb   = 8'($urandom);
    t.rlen  = 16'($urandom);
    t.hfail = 1'($urandom);
    t.hlen  = 11'($urandom);
    return t;
  endfunction

  task automatic send_token(input token_t t);
    while (!no_idle && $urandom_range(0, 99) < 32) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push                <= 1'b1;
    req_type_i          <= t.ev;
    dev_addr_i          <= t.addr;
    endpoint_i          <= t.ep;
    packet_length_i     <= t.plen;
    request_type_byte_i <= t.rtb;
    request_length_i    <= t.rlen;
    handler_failed_i    <= t.hfail;
    handler_length_i    <= t.hlen;
    do @(posedge clk_i); while (full_s);
    sb.note_token(t);
    sent++;
  endtask

  // stop offering and let every outstanding result come back
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // one well-formed control transfer with random content, now and then broken
  task automatic run_transfer();
    token_t      t;
    int unsigned n;
    if (sb.attach != AT_DEFAULT || $urandom_range(0, 9) == 0) begin
      t    = random_token();
      t.ev = EV_RESET;
      send_token(t);
      t    = random_token();
      t.ev = EV_SETADDR;
      send_token(t);
    end
    t      = random_token();
    t.ev   = EV_SETUP;
    t.addr = sb.address;
    t.plen = 10'(SetupPacketBytes);
    t.rlen = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
    t.hfail = ($urandom_range(0, 7) == 0);
    t.hlen = ($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'($urandom_range(0, 80));
    send_token(t);
    n = 0;
    while (sb.phase == PH_DATA && n < 48) begin
      t      = random_token();
      t.ev   = sb.dir_in ? EV_IN : EV_OUT;
      t.addr = sb.address;
      t.ep   = ($urandom_range(0, 15) == 0) ? 4'($urandom) : 4'd0;
      t.plen = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(1, 64));
      if ($urandom_range(0, 19) == 0) t.ev = sb.dir_in ? EV_OUT : EV_IN;
      send_token(t);
      n++;
    end
    if (sb.phase == PH_ACK) begin
      t       = random_token();
      t.ev    = sb.dir_in ? EV_OUT : EV_IN;
      t.addr  = sb.address;
      t.ep    = 4'd0;
      t.hfail = ($urandom_range(0, 7) == 0);
      send_token(t);
    end
  endtask

  initial begin
    bit drained_mid;
    drained_mid = 1'b0;
    sb = new();
    push                <= 1'b0;
    req_type_i          <= '0;
    dev_addr_i          <= '0;
    endpoint_i          <= '0;
    packet_length_i     <= '0;
    request_type_byte_i <= '0;
    request_length_i    <= '0;
    handler_failed_i    <= 1'b0;
    handler_length_i    <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: attach and reset handling, address checks, both transfer kinds
    send_token(make_token(EV_ATTACH, 7'd0, 4'd0, 10'd0, 8'h00, 16'd0, 1'b0, 11'd0));
    send_token(make_token(EV_SETUP, 7'd0, 4'd0, 10'd8, 8'h80, 16'd8, 1'b0, 11'd8));
    send_token(make_token(EV_RESET, 7'd0, 4'd0, 10'd0, 8'h00, 16'd0, 1'b0, 11'd0));
    send_token(make_token(EV_IN, 7'd5, 4'd0, 10'd8, 8'h00, 16'd0, 1'b0, 11'd0));
    send_token(make_token(EV_SETADDR, 7'd127, 4'd0, 10'd0, 8'h00, 16'd0, 1'b0, 11'd0));
    send_token(make_token(EV_SETUP, 7'd127, 4'd0, 10'd7, 8'h80, 16'd8, 1'b0, 11'd8));
    send_token(make_token(EV_IN, 7'd127, 4'd0, 10'd8, 8'h00, 16'd0, 1'b0, 11'd0));
    send_token(make_token(EV_SETUP, 7'd127, 4'd0, 10'd8, 8'h80, 16'hFFFF, 1'b1, 11'd1024));
    send_token(make_token(EV_IN, 7'd127, 4'd0, 10'd8, 8'h00, 16'd0, 1'b0, 11'd0));
    send_token(make_token(EV_SETUP, 7'd127, 4'd0, 10'd8, 8'hFF, 16'hFFFF, 1'b0, 11'd1024));
    send_token(make_token(EV_IN, 7'd127, 4'd15, 10'd8, 8'h00, 16'd0, 1'b0, 11'd0));
    send_token(make_token(EV_IN, 7'd127, 4'd0, 10'd1023, 8'h00, 16'd0, 1'b0, 11'd0));
    send_token(make_token(EV_IN, 7'd127, 4'd0, 10'd1023, 8'h00, 16'd0, 1'b0, 11'd0));
    send_token(make_token(EV_OUT, 7'd127, 4'd0, 10'd0, 8'h00, 16'd0, 1'b0, 11'd0));
    send_token(make_token(EV_SETUP, 7'd127, 4'd0, 10'd8, 8'h00, 16'd0, 1'b0, 11'd0));
    send_token(make_token(EV_OUT, 7'd127, 4'd0, 10'd0, 8'h00, 16'd0, 1'b0, 11'd0));
    send_token(make_token(EV_IN, 7'd127, 4'd0, 10'd0, 8'h00, 16'd0, 1'b1, 11'd0));
    send_token(make_token(EV_SETUP, 7'd127, 4'd0, 10'd8, 8'h7F, 16'd20, 1'b0, 11'd0));
    send_token(make_token(EV_OUT, 7'd127, 4'd0, 10'd8, 8'h00, 16'd0, 1'b0, 11'd0));
    send_token(make_token(EV_IN, 7'd127, 4'd0, 10'd8, 8'h00, 16'd0, 1'b0, 11'd0));
    send_token(make_token(EV_SETUP, 7'd127, 4'd0, 10'd8, 8'h80, 16'd100, 1'b0, 11'd2047));
    send_token(make_token(EV_OUT, 7'd127, 4'd0, 10'd8, 8'h00, 16'd0, 1'b0, 11'd0));
    send_token(make_token(EV_UNKNOWN, 7'd127, 4'd0, 10'd0, 8'h00, 16'd0, 1'b0, 11'd0));
    send_token(make_token(EV_DETACH, 7'd127, 4'd0, 10'd0, 8'h00, 16'd0, 1'b0, 11'd0));
    send_token(make_token(EV_IN, 7'd127, 4'd0, 10'd8, 8'h00, 16'd0, 1'b0, 11'd0));
    drain();

    while (sent < NumItems) begin
      no_idle = (sent >= 1200 && sent < 1500);
      if (!drained_mid && sent >= DrainAtItem) begin
        drained_mid = 1'b1;
        drain();
      end
      if ($urandom_range(0, 3) != 0) run_transfer();
      else send_token(random_token());
    end
    no_idle = 1'b0;

    drain();
    // keep the clock running so that any stray result is still caught
    repeat (8) @(posedge clk_i);
    sb.close_out();
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
